>>> hdl/b64d_pkg.sv
// Types, constants and the character classifier for the base64 stream decoder.
// No dependencies.
package b64d_pkg;

    localparam logic [5:0] CODE_LOWER_BASE = 6'd26;
    localparam logic [5:0] CODE_DIGIT_BASE = 6'd52;
    localparam logic [5:0] CODE_PLUS       = 6'd62;
    localparam logic [5:0] CODE_SLASH      = 6'd63;

    localparam logic [1:0] SLOT_FIRST  = 2'd0;
    localparam logic [1:0] SLOT_SECOND = 2'd1;
    localparam logic [1:0] SLOT_THIRD  = 2'd2;
    localparam logic [1:0] SLOT_FOURTH = 2'd3;

    localparam logic [1:0] IDX_BYTE0 = 2'd0;
    localparam logic [1:0] IDX_BYTE1 = 2'd1;
    localparam logic [1:0] IDX_BYTE2 = 2'd2;

    typedef struct packed {
        logic [5:0] code;
        logic       is_pad;
        logic       is_bad;
    } char_class_t;

    // One queued job: up to three result items from one input item.
    typedef struct packed {
        logic [2:0][7:0] bytes;
        logic [1:0]      last_idx;
        logic            err;
        logic            fin;
    } job_t;

    function automatic char_class_t classify(input logic [7:0] ch);
        char_class_t r;
        r.code   = '0;
        r.is_pad = 1'b0;
        r.is_bad = 1'b0;
        if (ch inside {[8'h41:8'h5A]})
        begin
            r.code = 6'(ch - 8'h41);
        end
        else if (ch inside {[8'h61:8'h7A]})
        begin
            r.code = 6'(ch - 8'h61) + CODE_LOWER_BASE;
        end
        else if (ch inside {[8'h30:8'h39]})
        begin
            r.code = 6'(ch - 8'h30) + CODE_DIGIT_BASE;
        end
        else if (ch == 8'h2B)
        begin
            r.code = CODE_PLUS;
        end
        else if (ch == 8'h2F)
        begin
            r.code = CODE_SLASH;
        end
        else if (ch == 8'h3D)
        begin
            r.is_pad = 1'b1;
        end
        else
        begin
            r.is_bad = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> hdl/base64_stream_decoder.sv
// Top level of the base64 stream decoder: front end, job queue, back end.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Takes one base64 character per cycle with valid/ready and emits decoded bytes,
// or a single error item, with valid/ready. The input side accepts an item every
// cycle while the job queue (QUEUE_DEPTH jobs) has room; a completed quartet
// becomes one job of one to three result items, which the back end issues at one
// per cycle, so a sustained rate of one character per cycle holds as long as the
// output side is ready. The fourth character of a quartet passes through the job
// queue and the held job register before its first byte is shown. After a fault,
// characters are absorbed without output until the one that carries stream_end.
module base64_stream_decoder
    import b64d_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       stream_end,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       decode_error,
    output logic       run_last,
    output logic       end_seen
);

    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    job_t push_job;
    job_t pop_job;

    b64d_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .stream_end (stream_end),
        .q_full     (q_full),
        .push       (q_push),
        .push_job   (push_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .full     (q_full),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .empty    (q_empty)
    );

    b64d_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_job        (pop_job),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .decode_error (decode_error),
        .run_last     (run_last),
        .end_seen     (end_seen)
    );

endmodule

>>> hdl/b64d_front.sv
// Front end: accepts characters, tracks quartet position and error latch,
// and builds one job per result-bearing item. Depends on b64d_pkg.
module b64d_front
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] char_in,
    input  logic       stream_end,
    input  logic       q_full,
    output logic       push,
    output job_t       push_job
);

    logic [1:0]  slot_reg, slot_next;
    logic        err_latched_reg, err_latched_next;
    logic        c_pad_reg, c_pad_next;
    logic [5:0]  a_reg, b_reg, c_reg;
    logic        accept;
    logic        fault;
    logic        emit;
    logic [1:0]  last_idx;
    char_class_t cls;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign cls      = classify(char_in);

    always_comb
    begin
        fault    = 1'b0;
        emit     = 1'b0;
        last_idx = IDX_BYTE2;
        if (slot_reg != SLOT_FOURTH)
        begin
            fault = cls.is_bad || (cls.is_pad && slot_reg != SLOT_THIRD) || stream_end;
        end
        else if (cls.is_bad)
        begin
            fault = 1'b1;
        end
        else if (c_pad_reg)
        begin
            fault    = !cls.is_pad || !stream_end;
            last_idx = IDX_BYTE0;
        end
        else if (cls.is_pad)
        begin
            fault    = !stream_end;
            last_idx = IDX_BYTE1;
        end
        emit = !err_latched_reg && (fault || slot_reg == SLOT_FOURTH);
    end

    always_comb
    begin
        push_job.fin = stream_end;
        push_job.err = fault;
        if (fault)
        begin
            push_job.bytes    = '0;
            push_job.last_idx = IDX_BYTE0;
        end
        else
        begin
            push_job.bytes[0] = {a_reg, b_reg[5:4]};
            push_job.bytes[1] = {b_reg[3:0], c_reg[5:2]};
            push_job.bytes[2] = {c_reg[1:0], cls.code};
            push_job.last_idx = last_idx;
        end
    end

    assign push = accept && emit;

    always_comb
    begin
        slot_next        = slot_reg;
        err_latched_next = err_latched_reg;
        c_pad_next       = c_pad_reg;
        if (accept)
        begin
            if (err_latched_reg)
            begin
                if (stream_end)
                begin
                    err_latched_next = 1'b0;
                    slot_next        = SLOT_FIRST;
                    c_pad_next       = 1'b0;
                end
            end
            else if (fault)
            begin
                err_latched_next = !stream_end;
                slot_next        = SLOT_FIRST;
                c_pad_next       = 1'b0;
            end
            else if (slot_reg == SLOT_FOURTH)
            begin
                slot_next  = SLOT_FIRST;
                c_pad_next = 1'b0;
            end
            else
            begin
                slot_next = slot_reg + 2'd1;
                if (slot_reg == SLOT_THIRD)
                begin
                    c_pad_next = cls.is_pad;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg        <= SLOT_FIRST;
            err_latched_reg <= 1'b0;
            c_pad_reg       <= 1'b0;
        end
        else
        begin
            slot_reg        <= slot_next;
            err_latched_reg <= err_latched_next;
            c_pad_reg       <= c_pad_next;
        end
    end

    // held codes; a pad is held as zero bits
    always_ff @(posedge clk)
    begin
        if (accept && !err_latched_reg && !fault)
        begin
            case (slot_reg)
                SLOT_FIRST:  a_reg <= cls.code;
                SLOT_SECOND: b_reg <= cls.code;
                SLOT_THIRD:  c_reg <= cls.code;
                default:     ;
            endcase
        end
    end

endmodule

>>> hdl/b64d_queue.sv
// Short job queue between front and back ends.
// Depends on b64d_pkg.
module b64d_queue
    import b64d_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    job_t          entries [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign full    = (count_reg == FULL_CNT);
    assign empty   = (count_reg == '0);
    assign pop_job = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !push)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        empty |-> !pop)
        else $error("job popped from empty queue");

endmodule

>>> hdl/b64d_back.sv
// Back end: takes jobs from the queue and issues their result items one per
// cycle while out_ready holds, from the held job register. Depends on b64d_pkg.
module b64d_back
    import b64d_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       q_empty,
    input  job_t       q_job,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       decode_error,
    output logic       run_last,
    output logic       end_seen
);

    job_t       job_reg;
    logic       busy_reg, busy_next;
    logic [1:0] idx_reg, idx_next;
    logic       is_last;
    logic       fire;

    assign is_last = (idx_reg == job_reg.last_idx);
    assign fire    = busy_reg && out_ready;
    assign pop     = !q_empty && (!busy_reg || (fire && is_last));

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (pop)
        begin
            busy_next = 1'b1;
            idx_next  = IDX_BYTE0;
        end
        else if (fire)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= IDX_BYTE0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            job_reg <= q_job;
        end
    end

    always_comb
    begin
        case (idx_reg)
            IDX_BYTE0: data_byte = job_reg.bytes[0];
            IDX_BYTE1: data_byte = job_reg.bytes[1];
            IDX_BYTE2: data_byte = job_reg.bytes[2];
            default:   data_byte = '0;
        endcase
    end

    assign out_valid    = busy_reg;
    assign byte_valid   = !job_reg.err;
    assign decode_error = job_reg.err;
    assign run_last     = is_last;
    assign end_seen     = is_last && job_reg.fin;

    a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_seen) |-> run_last)
        else $error("end_seen on a non-final item result");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && decode_error) |-> (run_last && !byte_valid && data_byte == 8'd0))
        else $error("malformed error result");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for base64_stream_decoder: directed and random character
// streams, predicted byte and error items checked field by field.
// Depends on b64d_pkg and the decoder RTL.
module tb_top;
    import b64d_pkg::*;

    localparam logic [7:0] CODE_PAD = 8'd64;
    localparam logic [7:0] CODE_BAD = 8'd255;
    localparam logic [7:0] CHAR_PAD = "=";

    typedef struct {
        logic [7:0] ch;
        logic       fin;
        logic       hold;
    } char_item_t;

    typedef struct {
        logic [7:0] data;
        logic       valid;
        logic       err;
        logic       last;
        logic       fin;
    } decoded_t;

    typedef enum int {RX_READY, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] char_in = 8'h00;
    logic       stream_end = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       decode_error;
    logic       run_last;
    logic       end_seen;

    char_item_t  pending_q[$];
    decoded_t    decoded_q[$];
    int unsigned mismatches = 0;
    int unsigned chars_taken = 0;
    int unsigned chars_total = 0;

    // decoder model state
    logic [1:0] quartet_pos = SLOT_FIRST;
    logic [7:0] held_codes[3] = '{8'd0, 8'd0, 8'd0};
    logic       faulted = 1'b0;

    int unsigned gap_left = 0;
    int unsigned burst_left = 0;
    logic        draining = 1'b0;
    rx_mode_t    rx_mode = RX_READY;
    int unsigned mode_left = 0;

    base64_stream_decoder uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_in      (char_in),
        .stream_end   (stream_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_byte    (data_byte),
        .byte_valid   (byte_valid),
        .decode_error (decode_error),
        .run_last     (run_last),
        .end_seen     (end_seen)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [7:0] char_code(input logic [7:0] ch);
        if (ch >= "A" && ch <= "Z")
            return ch - "A";
        if (ch >= "a" && ch <= "z")
            return ch - "a" + 8'(CODE_LOWER_BASE);
        if (ch >= "0" && ch <= "9")
            return ch - "0" + 8'(CODE_DIGIT_BASE);
        if (ch == "+")
            return 8'(CODE_PLUS);
        if (ch == "/")
            return 8'(CODE_SLASH);
        if (ch == CHAR_PAD)
            return CODE_PAD;
        return CODE_BAD;
    endfunction

    function automatic logic [7:0] b64_char(input int v);
        if (v < 26)
            return 8'("A" + v);
        if (v < 52)
            return 8'("a" + v - 26);
        if (v < 62)
            return 8'("0" + v - 52);
        if (v == 62)
            return "+";
        return "/";
    endfunction

    task automatic clear_decoder();
        quartet_pos = SLOT_FIRST;
        held_codes  = '{8'd0, 8'd0, 8'd0};
        faulted     = 1'b0;
    endtask

    task automatic push_fault(input logic fin);
        decoded_q.insert(decoded_q.size(), '{8'h00, 1'b0, 1'b1, 1'b1, fin});
        if (fin)
            clear_decoder();
        else
            faulted = 1'b1;
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic fin);
        logic [7:0] code;
        logic [5:0] a, b, c, d;
        logic [7:0] bytes[3];
        int         n;
        code = char_code(ch);
        if (faulted)
        begin
            if (fin)
                clear_decoder();
        end
        else if (quartet_pos != SLOT_FOURTH)
        begin
            if (code == CODE_BAD || fin || (code == CODE_PAD && quartet_pos != SLOT_THIRD))
                push_fault(fin);
            else
            begin
                held_codes[quartet_pos] = code;
                quartet_pos = quartet_pos + 2'd1;
            end
        end
        else if (code == CODE_BAD || (code == CODE_PAD && !fin)
                 || (held_codes[2] == CODE_PAD && (code != CODE_PAD || !fin)))
            push_fault(fin);
        else
        begin
            n = (held_codes[2] == CODE_PAD) ? 1 : (code == CODE_PAD) ? 2 : 3;
            a = held_codes[0][5:0];
            b = held_codes[1][5:0];
            c = held_codes[2][5:0];
            d = code[5:0];
            bytes[0] = {a, b[5:4]};
            bytes[1] = {b[3:0], c[5:2]};
            bytes[2] = {c[1:0], d};
            for (int k = 0; k < n; k++)
                decoded_q.insert(decoded_q.size(),
                                 '{bytes[k], 1'b1, 1'b0, k == n - 1, (k == n - 1) && fin});
            clear_decoder();
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic push_char(input logic [7:0] ch, input logic fin, input logic hold);
        pending_q.insert(pending_q.size(), '{ch, fin, hold});
    endtask

    task automatic push_text(input string s, input logic fin);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i], fin && (i == s.len() - 1), 1'b0);
    endtask

    // mostly well-formed streams, some corrupted, truncated or pure noise
    task automatic gen_stream(input logic hold);
        logic [7:0] s[$];
        int         nq;
        int         len;
        int         pads;
        int         kind;
        int         cut;
        nq = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
        for (int i = 0; i < 4 * nq; i++)
            s.insert(s.size(), b64_char($urandom_range(0, 63)));
        len  = s.size();
        pads = $urandom_range(0, 2);
        if (pads >= 1)
            s[len - 1] = CHAR_PAD;
        if (pads == 2)
            s[len - 2] = CHAR_PAD;
        kind = $urandom_range(0, 9);
        case (kind)
            0: s[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
            1: s[$urandom_range(0, len - 1)] = CHAR_PAD;
            2:
            begin
                cut = $urandom_range(1, len - 1);
                while (s.size() > cut)
                    s.delete(s.size() - 1);
            end
            3:
            begin
                s.delete();
                repeat ($urandom_range(1, 6))
                    s.insert(s.size(), 8'($urandom_range(0, 255)));
            end
            default: ;
        endcase
        for (int i = 0; i < s.size(); i++)
            push_char(s[i], i == s.size() - 1, hold && (i == 0));
    endtask

    always @(posedge clk or negedge rst_n)
    begin : drive
        char_item_t nxt;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            char_in    <= 8'h00;
            stream_end <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
            draining   <= 1'b0;
        end
        else if (!in_valid || in_ready)
        begin
            if (draining)
            begin
                in_valid <= 1'b0;
                if (decoded_q.size() == 0)
                    draining <= 1'b0;
            end
            else if (gap_left != 0)
            begin
                in_valid <= 1'b0;
                gap_left <= gap_left - 1;
            end
            else if (pending_q.size() != 0 && pending_q[0].hold)
            begin
                pending_q[0].hold = 1'b0;
                in_valid <= 1'b0;
                draining <= 1'b1;
            end
            else if (pending_q.size() != 0)
            begin
                nxt = pending_q.pop_front();
                in_valid   <= 1'b1;
                char_in    <= nxt.ch;
                stream_end <= nxt.fin;
                if (burst_left <= 1)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode   <= RX_READY;
            mode_left <= 0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                rx_mode   <= rx_mode_t'($urandom_range(0, 3));
                mode_left <= $urandom_range(8, 60);
            end
            else
                mode_left <= mode_left - 1;
            case (rx_mode)
                RX_READY:    out_ready <= 1'b1;
                RX_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   out_ready <= ($urandom_range(0, 5) == 0);
                RX_PERIODIC: out_ready <= (mode_left[2:0] != 3'd0);
                default:     out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin : monitor
        decoded_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                decode_char(char_in, stream_end);
                chars_taken++;
            end
            if (out_valid && out_ready)
            begin
                if (decoded_q.size() == 0)
                begin
                    $error("unexpected item: data_byte %0h byte_valid %0b decode_error %0b",
                           data_byte, byte_valid, decode_error);
                    mismatches++;
                end
                else
                begin
                    want = decoded_q.pop_front();
                    check_field("data_byte", want.data, data_byte);
                    check_field("byte_valid", 8'(want.valid), 8'(byte_valid));
                    check_field("decode_error", 8'(want.err), 8'(decode_error));
                    check_field("run_last", 8'(want.last), 8'(run_last));
                    check_field("end_seen", 8'(want.fin), 8'(end_seen));
                end
            end
        end
    end

    initial
    begin
        #2000000;
        $display("tb_top failed");
        $finish;
    end

    initial
    begin
        // three bytes then one byte, pads in third and fourth place
        push_text("TWFu", 1'b0);
        push_text("+z==", 1'b1);
        // two bytes, extreme codes
        push_text("//8=", 1'b1);
        // pad in third place without pad in fourth
        push_text("AB=A", 1'b1);
        // pad in second place, then ignored until the final item
        push_text("A=", 1'b0);
        push_char(8'hFF, 1'b1, 1'b0);
        // invalid byte as a lone final item
        push_char(8'h00, 1'b1, 1'b0);
        // truncated quartet
        push_text("QQ", 1'b1);
        // pad in fourth place on a non-final quartet
        push_text("AAB=", 1'b0);
        push_text("=", 1'b1);

        gen_stream(1'b1);
        while (pending_q.size() < 160)
            gen_stream($urandom_range(0, 11) == 0);
        chars_total = pending_q.size();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (chars_taken != chars_total)
            @(posedge clk);
        while (decoded_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

>>> base64_stream_decoder.f
hdl/b64d_pkg.sv
hdl/b64d_front.sv
hdl/b64d_queue.sv
hdl/b64d_back.sv
hdl/base64_stream_decoder.sv
test/tb_top.sv
